[src/byte_stream_find_replace_top_macros.svh]
// Assertion macros shared by the find/replace block.
`ifndef BYTE_STREAM_FIND_REPLACE_TOP_MACROS_SVH
`define BYTE_STREAM_FIND_REPLACE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define BSFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsfr check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define BSFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsfr check failed");

`endif

[src/bsfr_pkg.sv]
package bsfr_pkg;

   // Defaults for the top level parameters
   localparam int MAX_PATTERN_DEF = 8;
   localparam int MAX_REPLACE_DEF = 8;

   // Command word carries up to this many bytes
   localparam int CMD_BYTES = 8;
   localparam int CNT_W     = $clog2(CMD_BYTES + 1);
   localparam int OFF_W     = $clog2(CMD_BYTES);

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Header length after reset
   localparam logic [7:0] SKIP_RESET = 8'd20;

   // Register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_PATTERN_BYTES      = 3'd0;
   localparam csr_index_type CSR_PATTERN_LENGTH     = 3'd1;
   localparam csr_index_type CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam csr_index_type CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam csr_index_type CSR_SKIP_COUNT         = 3'd4;

   // Configuration as seen by the front
   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [63:0] replacement_bytes;
      logic [3:0]  replacement_length;
      logic [7:0]  skip_count;
   } cfg_type;

   // One command: bytes to emit in order, their count, end of stream mark.
   // A zero count with last set stands for the empty end marker.
   typedef struct packed {
      logic [8*CMD_BYTES-1:0] data;
      logic [CNT_W-1:0]       count;
      logic                   last;
   } cmd_type;

endpackage

[src/bsfr_front.sv]
module bsfr_front #(
   parameter int MAX_PATTERN = bsfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = bsfr_pkg::MAX_REPLACE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_stream,
   input  logic              queue_full,
   input  bsfr_pkg::cfg_type cfg,
   output logic              cmd_push,
   output bsfr_pkg::cmd_type cmd
);
   import bsfr_pkg::*;

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);

   logic [7:0]        window_ff [MAX_PATTERN];
   logic [7:0]        window_in [MAX_PATTERN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        bytes_seen_ff, bytes_seen_in;
   logic [3:0]        active_ff, active_in;

   logic [7:0]        win_new [MAX_PATTERN];
   logic [3:0]        fill_new;
   logic [3:0]        len_use;
   logic [3:0]        repl_len;
   logic              accept, pass, check, mismatch, match;

   assign accept = push & ~queue_full;

   // Pattern length is latched on the first byte of a stream
   always_comb begin
      if (bytes_seen_ff == 8'd0) begin
         if (cfg.pattern_length == 4'd0) begin
            len_use = 4'd1;
         end else if (cfg.pattern_length > 4'(MAX_PATTERN)) begin
            len_use = 4'(MAX_PATTERN);
         end else begin
            len_use = cfg.pattern_length;
         end
      end else begin
         len_use = active_ff;
      end
      repl_len = (cfg.replacement_length > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE)
                                                            : cfg.replacement_length;
   end

   // Classify the byte: header pass, match, window shift or window fill
   always_comb begin
      pass = (fill_ff == '0) && (bytes_seen_ff < cfg.skip_count);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         win_new[k] = (FILL_W'(k) == fill_ff) ? req_data_byte : window_ff[k];
      end
      fill_new = 4'(fill_ff) + 4'd1;
      check    = (fill_new >= len_use);
      mismatch = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if ((4'(k) < len_use) && (win_new[k] != cfg.pattern_bytes[8*k +: 8])) begin
            mismatch = 1'b1;
         end
      end
      match = check & ~mismatch;
   end

   // Build the command and the next window
   always_comb begin
      cmd.data  = '0;
      cmd.count = '0;
      cmd.last  = req_end_of_stream;
      window_in = window_ff;
      fill_in   = fill_ff;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         cmd.data[8*k +: 8] = win_new[k];
      end
      if (pass) begin
         cmd.data  = '0;
         cmd.data[7:0] = req_data_byte;
         cmd.count = CNT_W'(1);
      end else if (match) begin
         cmd.data  = cfg.replacement_bytes;
         cmd.count = CNT_W'(repl_len);
         fill_in   = '0;
      end else if (check) begin
         // oldest byte goes out; at end of stream the whole window goes out
         cmd.count = req_end_of_stream ? CNT_W'(fill_new) : CNT_W'(1);
         for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            window_in[k] = win_new[k + 1];
         end
         window_in[MAX_PATTERN-1] = 8'h00;
      end else begin
         cmd.count = req_end_of_stream ? CNT_W'(fill_new) : '0;
         window_in = win_new;
         fill_in   = FILL_W'(fill_new);
      end
      if (req_end_of_stream) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_in[k] = 8'h00;
         end
         fill_in = '0;
      end
   end

   assign cmd_push = accept && ((cmd.count != '0) || req_end_of_stream);

   // Header counter saturates; cleared at end of stream
   always_comb begin
      if (req_end_of_stream) begin
         bytes_seen_in = 8'd0;
      end else if (bytes_seen_ff == 8'hFF) begin
         bytes_seen_in = bytes_seen_ff;
      end else begin
         bytes_seen_in = bytes_seen_ff + 8'd1;
      end
      active_in = len_use;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         bytes_seen_ff <= 8'd0;
         active_ff     <= 4'd1;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_ff[k] <= 8'h00;
         end
      end else if (accept) begin
         fill_ff       <= fill_in;
         bytes_seen_ff <= bytes_seen_in;
         active_ff     <= active_in;
         window_ff     <= window_in;
      end
   end

endmodule

[src/bsfr_queue.sv]
module bsfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_push,
   input  bsfr_pkg::cmd_type cmd_in,
   output logic              queue_full,
   input  logic              queue_pop,
   output logic              queue_valid,
   output bsfr_pkg::cmd_type queue_head
);
   import bsfr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   cmd_type           store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign queue_full  = (count_ff == CNT_Q'(QUEUE_DEPTH));
   assign queue_valid = (count_ff != '0);
   assign queue_head  = store_ff[rd_ptr_ff];
   assign do_push     = cmd_push & ~queue_full;
   assign do_pop      = queue_pop & queue_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_Q'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

[src/bsfr_back.sv]
module bsfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_valid,
   input  bsfr_pkg::cmd_type queue_head,
   output logic              queue_pop,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last_out
);
   import bsfr_pkg::*;

   logic [OFF_W-1:0] off_ff, off_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             last_ff, last_in;
   logic             load_ok, emit, final_byte;

   assign load_ok    = ~out_valid_ff | pop;
   assign emit       = queue_valid & load_ok;
   assign final_byte = (CNT_W'(off_ff) + CNT_W'(1) == queue_head.count);

   // Head bytes load the output register one per cycle; pop low stalls
   always_comb begin
      off_in        = off_ff;
      queue_pop     = 1'b0;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff & ~pop;
      if (emit) begin
         out_valid_in = 1'b1;
         if (queue_head.count == '0) begin
            // empty end marker
            out_byte_in   = 8'h00;
            byte_valid_in = 1'b0;
            last_in       = queue_head.last;
            queue_pop     = 1'b1;
         end else begin
            out_byte_in   = queue_head.data[8*off_ff +: 8];
            byte_valid_in = 1'b1;
            last_in       = queue_head.last & final_byte;
            if (final_byte) begin
               queue_pop = 1'b1;
               off_in    = '0;
            end else begin
               off_in = off_ff + OFF_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
   end

   assign empty          = ~out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last_out   = last_ff;

endmodule

[src/byte_stream_find_replace_top.sv]
// Streaming byte find and replace.
// Input queue port: push a byte with req_data_byte and req_end_of_stream
// while full is low. Output queue port: while empty is low, rsp_out_byte,
// rsp_byte_valid and rsp_last_out show the oldest result; pop takes it.
// The first skip_count bytes of each stream pass unchanged; after them each
// leftmost non-overlapping pattern occurrence is swapped for the replacement.
// A stream that ends with nothing left to send yields one result with
// rsp_byte_valid low and rsp_last_out high.
// A taken request's command enters the command queue, and its bytes move one
// by one into the output register. One byte per cycle goes in while full is
// low and out while pop is high; each command holds the back end until its
// bytes are out; the four-entry queue absorbs short bursts before full rises.
// Requests that only fill the window send nothing to the back end.
// When pop stays low, results wait in the output register and queue, and
// full rises once the queue is full; nothing is dropped.
// Reset (synchronous) empties the queue and window and restores the
// registers: pattern length 1, replacement length 0, skip count 20.
// Configuration writes are registered; pattern length is latched per stream.
`include "byte_stream_find_replace_top_macros.svh"

module byte_stream_find_replace_top #(
   parameter int MAX_PATTERN = bsfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = bsfr_pkg::MAX_REPLACE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_end_of_stream,
   output logic                    empty,
   input  logic                    pop,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_last_out,
   input  logic                    csr_write_en,
   input  bsfr_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata
);
   import bsfr_pkg::*;

   cfg_type cfg_ff;
   logic    cmd_push, queue_full, queue_pop, queue_valid;
   cmd_type cmd, queue_head;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes      <= 64'd0;
         cfg_ff.pattern_length     <= 4'd1;
         cfg_ff.replacement_bytes  <= 64'd0;
         cfg_ff.replacement_length <= 4'd0;
         cfg_ff.skip_count         <= SKIP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      cfg_ff.pattern_bytes      <= csr_wdata;
            CSR_PATTERN_LENGTH:     cfg_ff.pattern_length     <= csr_wdata[3:0];
            CSR_REPLACEMENT_BYTES:  cfg_ff.replacement_bytes  <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_ff.replacement_length <= csr_wdata[3:0];
            CSR_SKIP_COUNT:         cfg_ff.skip_count         <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign full = queue_full;

   bsfr_front #(
      .MAX_PATTERN(MAX_PATTERN),
      .MAX_REPLACE(MAX_REPLACE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_full        (queue_full),
      .cfg               (cfg_ff),
      .cmd_push          (cmd_push),
      .cmd               (cmd)
   );

   bsfr_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .cmd_push    (cmd_push),
      .cmd_in      (cmd),
      .queue_full  (queue_full),
      .queue_pop   (queue_pop),
      .queue_valid (queue_valid),
      .queue_head  (queue_head)
   );

   bsfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_valid    (queue_valid),
      .queue_head     (queue_head),
      .queue_pop      (queue_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last_out   (rsp_last_out)
   );

   // Front never writes a command into a full queue
   `BSFR_ASSERT_NOW(a_no_overflow, cmd_push, !queue_full)
   // A command written into an empty queue is visible the next cycle
   `BSFR_ASSERT_NEXT(a_push_visible, cmd_push && !queue_valid && !reset, queue_valid)
   // An empty result is always the zero end marker
   `BSFR_ASSERT_NOW(a_marker_form, !empty && !rsp_byte_valid, rsp_last_out && rsp_out_byte == 8'h00)

endmodule

[tb/byte_stream_find_replace_top_tb.sv]
`timescale 1ns / 100ps

module byte_stream_find_replace_top_tb;
   import bsfr_pkg::*;

   // One patched output byte as the block shows it
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } patched_type;

   logic          clock;
   logic          reset;
   logic          push;
   logic          full;
   logic [7:0]    req_data_byte;
   logic          req_end_of_stream;
   logic          empty;
   logic          pop;
   logic [7:0]    rsp_out_byte;
   logic          rsp_byte_valid;
   logic          rsp_last_out;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [63:0]   csr_wdata;

   byte_stream_find_replace_top DUT (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_out      (rsp_last_out),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Patcher copy: registers
   logic [63:0] pat_bytes;
   logic [3:0]  pat_len;
   logic [63:0] rep_bytes;
   logic [3:0]  rep_len;
   logic [7:0]  skip_len;

   // Patcher copy: stream state
   logic [7:0]  win [8];
   int          win_fill;
   int          seen;
   int          active_len;

   patched_type pending_bytes [$];

   int mismatches;
   int bytes_sent;
   int streams_sent;
   int results_checked;
   int header_results;
   bit send_idle;
   bit recv_idle;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop
   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

   // Compute the bytes one request yields and queue them up
   task automatic predict_patch(input logic [7:0] d, input logic eos);
      patched_type burst [$];
      int          k;
      int          rl;
      bit          hit;
      if (seen == 0)
         active_len = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : int'(pat_len));
      if (win_fill == 0 && seen < skip_len) begin
         burst.push_back('{d, 1'b1, 1'b0});
         header_results++;
      end else begin
         if (win_fill < 8) begin
            win[win_fill] = d;
            win_fill++;
         end
         if (win_fill >= active_len) begin
            hit = 1'b1;
            for (k = 0; k < active_len; k++)
               if (win[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
            if (hit) begin
               rl = (rep_len > 8) ? 8 : int'(rep_len);
               for (k = 0; k < rl; k++)
                  burst.push_back('{rep_bytes[8*k +: 8], 1'b1, 1'b0});
               win_fill = 0;
            end else begin
               burst.push_back('{win[0], 1'b1, 1'b0});
               for (k = 1; k < win_fill; k++) win[k-1] = win[k];
               win_fill--;
            end
         end
      end
      if (seen < 255) seen++;
      // End of stream: flush the window, mark the last result
      if (eos) begin
         for (k = 0; k < win_fill; k++)
            burst.push_back('{win[k], 1'b1, 1'b0});
         if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0});
         burst[burst.size()-1].last = 1'b1;
         for (k = 0; k < 8; k++) win[k] = 8'h00;
         win_fill = 0;
         seen = 0;
      end
      foreach (burst[i]) pending_bytes.push_back(burst[i]);
   endtask

   // Send one request, predict it once taken, then maybe hold off
   task automatic send_byte(input logic [7:0] d, input logic eos);
      push              <= 1'b1;
      req_data_byte     <= d;
      req_end_of_stream <= eos;
      do @(posedge clock); while (full);
      predict_patch(d, eos);
      bytes_sent++;
      if (eos) streams_sent++;
      if (send_idle && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Wait until every expected result has been taken and the block is quiet
   task automatic settle();
      push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_BYTES:      pat_bytes = v;
         CSR_PATTERN_LENGTH:     pat_len   = v[3:0];
         CSR_REPLACEMENT_BYTES:  rep_bytes = v;
         CSR_REPLACEMENT_LENGTH: rep_len   = v[3:0];
         CSR_SKIP_COUNT:         skip_len  = v[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] pb, input logic [3:0] pl,
                             input logic [63:0] rb, input logic [3:0] rl,
                             input logic [7:0] sk);
      write_reg(CSR_PATTERN_BYTES, pb);
      write_reg(CSR_PATTERN_LENGTH, 64'(pl));
      write_reg(CSR_REPLACEMENT_BYTES, rb);
      write_reg(CSR_REPLACEMENT_LENGTH, 64'(rl));
      write_reg(CSR_SKIP_COUNT, 64'(sk));
   endtask

   // Stream of random content seeded with whole and partial pattern copies
   task automatic send_stream(input int len);
      int         sent;
      int         plen;
      int         take;
      int         k;
      int         pick;
      logic [7:0] d;
      plen = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : int'(pat_len));
      sent = 0;
      while (sent < len) begin
         case ($urandom_range(0, 9))
            0, 1, 2: take = plen;
            3:       take = $urandom_range(1, plen);
            default: take = 0;
         endcase
         if (take == 0) begin
            pick = $urandom_range(0, plen - 1);
            d = ($urandom_range(0, 1) != 0) ? 8'($urandom) : pat_bytes[8*pick +: 8];
            send_byte(d, sent == len - 1);
            sent++;
         end else begin
            for (k = 0; k < take && sent < len; k++) begin
               send_byte(pat_bytes[8*k +: 8], sent == len - 1);
               sent++;
            end
         end
      end
   endtask

   task automatic random_config();
      logic [63:0] pb;
      logic [3:0]  pl;
      logic [3:0]  rl;
      logic [7:0]  sk;
      pb = {$urandom, $urandom};
      // repeated byte pattern exercises the leftmost non-overlapping rule
      if ($urandom_range(0, 3) == 0) pb = {8{pb[7:0]}};
      if ($urandom_range(0, 7) == 0)
         pl = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
      else
         pl = 4'($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) rl = 4'($urandom_range(9, 15));
      else rl = 4'($urandom_range(0, 8));
      sk = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(6, 40))
                                       : 8'($urandom_range(0, 5));
      set_config(pb, pl, {$urandom, $urandom}, rl, sk);
   endtask

   // Registers at reset values: whole stream falls inside the 20-byte header
   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();
   endtask

   // Two-byte pattern swapped for eight bytes, partial match flushed at end
   task automatic test_expanding_replace();
      set_config(64'h0000_0000_0000_ABCD, 4'd2, 64'h8877_6655_4433_2211, 4'd8, 8'd0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hCD, 1'b1);
      settle();
   endtask

   // Zero-length replacement deletes; nothing left at end gives the empty marker
   task automatic test_delete_and_empty_end();
      set_config(64'h0000_0000_0000_005A, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'd0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h5A, 1'b1);
      settle();
   endtask

   // Out-of-range lengths clamp; stream shorter than the pattern passes as is
   task automatic test_length_limits();
      int k;
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 8'd0);
      for (k = 0; k < 3; k++) send_byte(8'hFF, k == 2);
      for (k = 0; k < 8; k++) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();
      set_config(64'h0, 4'd0, 64'h80, 4'd1, 8'd0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      settle();
   endtask

   // Writes while a byte sits in the window
   task automatic test_mid_stream_writes();
      set_config(64'h0000_0000_0000_3CC3, 4'd2, 64'h0000_0000_00A1_B2C3, 4'd3, 8'd0);
      send_byte(8'hC3, 1'b0);
      settle();
      // new length waits for the next stream, the rest acts now
      write_reg(CSR_PATTERN_LENGTH, 64'd1);
      write_reg(CSR_REPLACEMENT_BYTES, 64'h0000_0000_0055_6677);
      write_reg(CSR_SKIP_COUNT, 64'd10);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b1);
      settle();
      write_reg(CSR_SKIP_COUNT, 64'd0);
      send_byte(8'h11, 1'b0);
      send_byte(8'hC3, 1'b1);
      settle();
   endtask

   // Long header: the first 40 bytes pass, the rest are matched
   task automatic test_long_header();
      int k;
      set_config(64'h0000_0000_0000_0077, 4'd1, 64'h0000_0000_0000_0099, 4'd1, 8'd40);
      for (k = 0; k < 44; k++) send_byte(8'h77, k == 43);
      settle();
   endtask

   // Random configurations, each followed by a run of streams
   task automatic test_random_streams(input int target);
      int start;
      int phase_end;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         settle();
         if (target - (bytes_sent - start) <= 40) begin
            send_idle = 1'b0;
            recv_idle = 1'b0;
         end else begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
         end
         random_config();
         phase_end = bytes_sent + 30;
         while (bytes_sent < phase_end)
            send_stream(($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16));
      end
   endtask

   // Result side: random pop stalls
   initial begin : pop_driver
      int stall;
      stall = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) stall--;
         else if (recv_idle && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 9);
         pop <= (stall == 0);
      end
   end

   // Compare each taken result with the oldest expected one
   always @(posedge clock) begin : check_results
      patched_type want;
      if (!reset && pop && !empty) begin
         if (pending_bytes.size() == 0) begin
            mismatches++;
            $display("%0t: expected nothing, got byte %h valid %b last %b", $time,
                     rsp_out_byte, rsp_byte_valid, rsp_last_out);
         end else begin
            want = pending_bytes.pop_front();
            results_checked++;
            if ({rsp_out_byte, rsp_byte_valid, rsp_last_out} !== want) begin
               mismatches++;
               $display("%0t: expected byte %h valid %b last %b, got byte %h valid %b last %b",
                        $time, want.data, want.valid, want.last,
                        rsp_out_byte, rsp_byte_valid, rsp_last_out);
            end
         end
      end
   end

   // Main sequence
   initial begin
      reset             <= 1'b1;
      push              <= 1'b0;
      req_data_byte     <= 8'h00;
      req_end_of_stream <= 1'b0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_PATTERN_BYTES;
      csr_wdata         <= 64'h0;
      mismatches      = 0;
      bytes_sent      = 0;
      streams_sent    = 0;
      results_checked = 0;
      header_results  = 0;
      send_idle       = 1'b1;
      recv_idle       = 1'b1;
      pat_bytes  = 64'h0;
      pat_len    = 4'd1;
      rep_bytes  = 64'h0;
      rep_len    = 4'd0;
      skip_len   = SKIP_RESET;
      for (int k = 0; k < 8; k++) win[k] = 8'h00;
      win_fill   = 0;
      seen       = 0;
      active_len = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_expanding_replace();
      test_delete_and_empty_end();
      test_length_limits();
      test_mid_stream_writes();
      test_long_header();
      test_random_streams(120);

      settle();
      repeat (20) @(posedge clock);
      $display("tb: %0d bytes in %0d streams, %0d results checked (%0d in headers)",
               bytes_sent, streams_sent, results_checked, header_results);
      $display("tb: covered clamped lengths, deletion, empty end, mid-stream writes, long header");
      if (mismatches == 0 && pending_bytes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
